[design/aald_pkg.sv]
// ----------------------------------------------------------------------------
// aald_pkg
// Shared types, constants and helpers of the area-average line downsampler.
// ----------------------------------------------------------------------------
package aald_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_LINE_DEF  = 4096;

  localparam int RATIO_W  = 17;
  localparam int INV_W    = 16;
  localparam int DCOUNT_W = 13;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [RATIO_W-1:0]  RATIO_RESET  = 17'd98304;
  localparam logic [INV_W-1:0]    INV_RESET    = 16'd43691;
  localparam logic [DCOUNT_W-1:0] DCOUNT_RESET = 13'd640;

  typedef enum logic [1:0] {
    REG_RATIO = 2'd0,
    REG_INV   = 2'd1,
    REG_COUNT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    FR_IDLE = 2'd0,
    FR_MUL  = 2'd1,
    FR_ACC  = 2'd2
  } front_state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first_of_line;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last_of_line;
  } out_item_t;

  // Convert a Q1.16 ratio to frac fraction bits (truncating) and clamp it to
  // the open interval (1, 2).
  function automatic logic [31:0] ratio_eff(input logic [RATIO_W-1:0] r, input int frac);
    logic [63:0] conv;
    logic [63:0] lo;
    logic [63:0] hi;
    conv = (64'(r) << frac) >> 16;
    lo   = (64'd1 << frac) + 64'd1;
    hi   = (64'd2 << frac) - 64'd1;
    if (conv < lo) begin
      conv = lo;
    end else if (conv > hi) begin
      conv = hi;
    end
    return conv[31:0];
  endfunction

endpackage

[design/area_average_line_downsampler.sv]
// ----------------------------------------------------------------------------
// area_average_line_downsampler
// Area-averaging scan line shrinker for ratios between 1 and 2.
// ----------------------------------------------------------------------------
// Usage: each accepted sample passes the front sequencer's accept and area
// update states, plus an accumulate state when an output boundary falls
// inside it (that state adds the split product into the sum and hands it to
// the queue). The input rate is set by that sequencer and its single
// multiplier: a new sample is taken only once the last one is through, and
// the input waits longer only while the queue is full. Finished sums wait in
// a two-entry queue, then pass a two-stage normalizer (partial products,
// rounding add) into the saturating output register. The input side keeps
// working while a result waits on the output, until the queue fills.
// Samples after dest_count outputs of a line produce nothing until
// first_of_line. Configure through the APB port only while the block is
// idle: ratio_q at 0x0, inv_ratio_q at 0x4, dest_count at 0x8.
// ----------------------------------------------------------------------------
module area_average_line_downsampler import aald_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_LINE  = MAX_LINE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item
);

  localparam int ACC_W  = SAMPLE_W + FRAC_BITS + 2;
  localparam int CNT_W  = $clog2(MAX_LINE + 1);
  localparam int DIST_W = FRAC_BITS + 1;

  // configuration registers
  logic [RATIO_W-1:0]  ratio_q;
  logic [INV_W-1:0]    inv_ratio_q;
  logic [DCOUNT_W-1:0] dest_count;

  reg_idx_t            reg_idx;
  logic                wr_en;
  logic [31:0]         ratio_conv;
  logic [DIST_W-1:0]   eff_ratio;
  logic [CNT_W-1:0]    eff_count;

  // front to queue
  logic                push_valid;
  logic                push_ready;
  logic signed [ACC_W-1:0] push_acc;
  logic                push_last;

  // queue to back
  logic                pop_valid;
  logic                pop_ready;
  logic [ACC_W:0]      pop_data;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_q     <= RATIO_RESET;
      inv_ratio_q <= INV_RESET;
      dest_count  <= DCOUNT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RATIO: ratio_q     <= pwdata[RATIO_W-1:0];
        REG_INV:   inv_ratio_q <= pwdata[INV_W-1:0];
        REG_COUNT: dest_count  <= pwdata[DCOUNT_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RATIO: prdata = DATA_W'(ratio_q);
      REG_INV:   prdata = DATA_W'(inv_ratio_q);
      REG_COUNT: prdata = DATA_W'(dest_count);
      default:   prdata = '0;
    endcase
  end

  // Bring the ratio to the internal fraction width and clamp it so that at
  // most one boundary lands in any sample; cap the line length.
  assign ratio_conv = ratio_eff(ratio_q, FRAC_BITS);
  assign eff_ratio  = ratio_conv[DIST_W-1:0];
  assign eff_count  = (32'(dest_count) > 32'(MAX_LINE)) ? CNT_W'(MAX_LINE)
                                                        : CNT_W'(dest_count);

  aald_front #(
    .FRAC_BITS (FRAC_BITS),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .eff_ratio  (eff_ratio),
    .eff_count  (eff_count),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_acc   (push_acc),
    .push_last  (push_last)
  );

  // hold each finished sum with its end-of-line flag on top
  aald_queue #(
    .WIDTH (ACC_W + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_last, push_acc}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  aald_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pop_valid),
    .in_ready  (pop_ready),
    .acc       ($signed(pop_data[ACC_W-1:0])),
    .last      (pop_data[ACC_W]),
    .inv_ratio (inv_ratio_q),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

`ifndef NO_ASSERTIONS
  a_clamped_ratio: assert property (@(posedge clk) disable iff (rst)
    eff_ratio > (DIST_W'(1) << FRAC_BITS))
    else $error("effective ratio not above one");
`endif

endmodule

[design/aald_front.sv]
// ----------------------------------------------------------------------------
// aald_front
// Accepts samples, tracks the output boundary and accumulates weighted area;
// hands each finished sum to the queue.
// ----------------------------------------------------------------------------
module aald_front import aald_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int CNT_W     = 13
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  in_item_t                            in_item,
  input  logic [FRAC_BITS:0]                  eff_ratio,
  input  logic [CNT_W-1:0]                    eff_count,
  output logic                                push_valid,
  input  logic                                push_ready,
  output logic signed [SAMPLE_W+FRAC_BITS+1:0] push_acc,
  output logic                                push_last
);

  localparam int ACC_W  = SAMPLE_W + FRAC_BITS + 2;
  localparam int DIST_W = FRAC_BITS + 1;
  localparam logic [DIST_W-1:0] ONE        = DIST_W'(1) << FRAC_BITS;
  localparam logic [31:0]       DIST_RST32 = ratio_eff(RATIO_RESET, FRAC_BITS);
  localparam logic [DIST_W-1:0] DIST_RESET = DIST_RST32[DIST_W-1:0];

  front_state_t             state;
  front_state_t             state_next;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [DIST_W-1:0]        bnd_dist;
  logic signed [ACC_W-1:0]  ws;
  logic signed [ACC_W-1:0]  prod;
  logic [CNT_W-1:0]         done;
  logic [CNT_W-1:0]         done_inc;
  logic signed [ACC_W-1:0]  s_full;
  logic [DIST_W:0]          reload_wide;
  logic [DIST_W-1:0]        dist_reload;

  // sample times one full unit of length
  assign s_full      = {{(ACC_W-SAMPLE_W-FRAC_BITS){sample_r[SAMPLE_W-1]}}, sample_r,
                        {FRAC_BITS{1'b0}}};
  assign done_inc    = done + CNT_W'(1);
  assign reload_wide = {1'b0, eff_ratio} + {1'b0, bnd_dist} - {1'b0, ONE};
  assign dist_reload = reload_wide[DIST_W-1:0];

  assign push_acc  = ws + prod;
  assign push_last = (done_inc == eff_count);

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: begin
        if (in_valid) state_next = FR_MUL;
      end
      FR_MUL: begin
        if (done < eff_count && bnd_dist <= ONE) state_next = FR_ACC;
        else state_next = FR_IDLE;
      end
      FR_ACC: begin
        if (push_ready) state_next = FR_IDLE;
      end
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    push_valid = 1'b0;
    unique case (state)
      FR_IDLE: in_ready   = 1'b1;
      FR_MUL:  ;
      FR_ACC:  push_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FR_IDLE;
      bnd_dist <= DIST_RESET;
      ws       <= '0;
      done     <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        FR_IDLE: begin
          if (in_valid) begin
            sample_r <= in_item.sample;
            if (in_item.first_of_line) begin
              bnd_dist <= eff_ratio;
              ws       <= '0;
              done     <= '0;
            end
          end
        end
        FR_MUL: begin
          if (done < eff_count) begin
            if (bnd_dist > ONE) begin
              ws       <= ws + s_full;
              bnd_dist <= bnd_dist - ONE;
            end else begin
              prod <= sample_r * $signed({1'b0, bnd_dist});
            end
          end
        end
        FR_ACC: begin
          if (push_ready) begin
            // the part of the sample past the boundary opens the next sum
            ws       <= s_full - prod;
            bnd_dist <= dist_reload;
            done     <= done_inc;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_dist_nonzero: assert property (@(posedge clk) disable iff (rst) bnd_dist != '0)
    else $error("boundary distance reached zero");

  a_line_start: assert property (@(posedge clk) disable iff (rst)
    (state == FR_IDLE && in_valid && in_item.first_of_line) |=> (done == '0 && ws == '0))
    else $error("line start did not clear the accumulator");
`endif

endmodule

[design/aald_queue.sv]
// ----------------------------------------------------------------------------
// aald_queue
// Short FIFO of finished sums between the front and the back.
// ----------------------------------------------------------------------------
module aald_queue import aald_pkg::*; #(
  parameter int WIDTH = 35,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt != CNT_W'(DEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) cnt <= cnt + CNT_W'(1);
      else if (do_pop && !do_push) cnt <= cnt - CNT_W'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");
`endif

endmodule

[design/aald_back.sv]
// ----------------------------------------------------------------------------
// aald_back
// Normalizes each sum by the reciprocal ratio, rounds, saturates and holds
// the result for the output channel.
// ----------------------------------------------------------------------------
module aald_back import aald_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_W+FRAC_BITS+1:0] acc,
  input  logic                                last,
  input  logic [INV_W-1:0]                    inv_ratio,
  output logic                                out_valid,
  input  logic                                out_ready,
  output out_item_t                           out_item
);

  localparam int ACC_W = SAMPLE_W + FRAC_BITS + 2;
  localparam int PHI_W = ACC_W + 1;
  localparam int PLO_W = 2 * INV_W;
  localparam int TOT_W = ACC_W + INV_W + 1;
  localparam int RES_W = TOT_W - FRAC_BITS - INV_W;
  localparam logic [TOT_W-1:0] HALF = {{(TOT_W-1){1'b0}}, 1'b1} << (FRAC_BITS + INV_W - 1);
  localparam logic signed [RES_W-1:0] SAT_MAX =
    RES_W'((64'd1 << (SAMPLE_W - 1)) - 64'd1);
  localparam logic signed [RES_W-1:0] SAT_MIN = ~SAT_MAX;

  logic                     advance;
  logic                     s1_valid;
  logic signed [PHI_W-1:0]  p_hi;
  logic [PLO_W-1:0]         p_lo;
  logic                     s1_last;
  logic                     s2_valid;
  logic signed [RES_W-1:0]  res;
  logic                     s2_last;
  logic [TOT_W-1:0]         tot;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // partial products recombined, plus half an LSB for rounding
  assign tot = {p_hi, {INV_W{1'b0}}} + TOT_W'(p_lo) + HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_hi    <= $signed(acc[ACC_W-1:INV_W]) * $signed({1'b0, inv_ratio});
      p_lo    <= acc[INV_W-1:0] * inv_ratio;
      s1_last <= last;
      res     <= $signed(tot[TOT_W-1:FRAC_BITS+INV_W]);
      s2_last <= s1_last;
      if (res > SAT_MAX) out_item.value <= SAT_MAX[SAMPLE_W-1:0];
      else if (res < SAT_MIN) out_item.value <= SAT_MIN[SAMPLE_W-1:0];
      else out_item.value <= res[SAMPLE_W-1:0];
      out_item.last_of_line <= s2_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_s1_to_s2: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid) |=> s2_valid)
    else $error("normalize stage dropped an item");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!advance && s2_valid) |=> s2_valid)
    else $error("stalled pipeline lost an item");
`endif

endmodule

[verif/aald_average_checker.sv]
// ----------------------------------------------------------------------------
// aald_average_checker
// Watches the configuration port and both item channels of the area-average
// line downsampler, predicts every output item and compares it field by field.
// ----------------------------------------------------------------------------
module aald_average_checker
  import aald_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_item_t          in_item,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_item_t         out_item,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC = FRAC_BITS_DEF;
  localparam longint UNIT = longint'(1) << FRAC;

  logic [RATIO_W-1:0]  ratio_reg;
  logic [INV_W-1:0]    inv_reg;
  logic [DCOUNT_W-1:0] count_reg;

  longint    span_left;
  longint    area_sum;
  int        outs_in_line;
  int        mismatches;
  out_item_t expected_outputs[$];

  // Ratio in internal fraction bits, held strictly inside (1, 2).
  function automatic longint boundary_span(input logic [RATIO_W-1:0] r);
    longint v;
    v = (longint'(r) << FRAC) >>> 16;
    if (v < UNIT + 1) begin
      v = UNIT + 1;
    end else if (v > 2 * UNIT - 1) begin
      v = 2 * UNIT - 1;
    end
    return v;
  endfunction

  function automatic int outputs_per_line(input logic [DCOUNT_W-1:0] c);
    return (int'(c) > MAX_LINE_DEF) ? MAX_LINE_DEF : int'(c);
  endfunction

  // floor(acc * inv / 2^(FRAC+16) + 1/2), saturated to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] area_average(input longint acc,
                                                              input logic [INV_W-1:0] inv);
    longint q;
    longint top_v;
    longint bot_v;
    top_v = (longint'(1) << (SAMPLE_W - 1)) - 1;
    bot_v = -top_v - 1;
    q = (acc * longint'(inv) + (longint'(1) << (FRAC + 15))) >>> (FRAC + 16);
    if (q > top_v) begin
      q = top_v;
    end else if (q < bot_v) begin
      q = bot_v;
    end
    return q[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    longint    s;
    longint    rest;
    out_item_t want;
    if (rst) begin
      ratio_reg = RATIO_RESET;
      inv_reg   = INV_RESET;
      count_reg = DCOUNT_RESET;
      span_left = boundary_span(RATIO_RESET);
      area_sum  = 0;
      outs_in_line = 0;
      expected_outputs.delete();
    end else begin
      // Compare first so an item can never match its own expectation in one edge.
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          $error("unexpected output item: value %0d last_of_line %0d",
                 out_item.value, out_item.last_of_line);
          mismatches++;
        end else begin
          want = expected_outputs.pop_front();
          if (out_item.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_item.value);
            mismatches++;
          end
          if (out_item.last_of_line !== want.last_of_line) begin
            $error("last_of_line: expected %0d, got %0d",
                   want.last_of_line, out_item.last_of_line);
            mismatches++;
          end
        end
      end

      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_RATIO: ratio_reg = pwdata[RATIO_W-1:0];
          REG_INV:   inv_reg   = pwdata[INV_W-1:0];
          REG_COUNT: count_reg = pwdata[DCOUNT_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        s = longint'(in_item.sample);
        if (in_item.first_of_line) begin
          span_left = boundary_span(ratio_reg);
          area_sum  = 0;
          outs_in_line = 0;
        end
        if (outs_in_line < outputs_per_line(count_reg)) begin
          if (span_left > UNIT) begin
            area_sum  += s * UNIT;
            span_left -= UNIT;
          end else begin
            area_sum += s * span_left;
            want.value = area_average(area_sum, inv_reg);
            rest = UNIT - span_left;
            area_sum  = s * rest;
            span_left = boundary_span(ratio_reg) - rest;
            outs_in_line++;
            want.last_of_line = (outs_in_line == outputs_per_line(count_reg));
            expected_outputs.push_back(want);
          end
        end
      end
    end
    errors  <= mismatches;
    pending <= expected_outputs.size();
  end

endmodule

[verif/area_average_line_downsampler_test.sv]
// ----------------------------------------------------------------------------
// area_average_line_downsampler_test
// Drives scan lines through the downsampler under many register settings,
// with random gaps on both channels and one long output stall; a checker
// beside the block predicts and compares every output item.
// ----------------------------------------------------------------------------
module area_average_line_downsampler_test import aald_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 16;       // margin for results still in the pipeline
  localparam int LONG_HOLD    = 400;      // long enough to fill the result queue
  localparam int CYCLE_LIMIT  = 1000000;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [DATA_W-1:0] pwdata   = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_item  = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_item;

  int errors;
  int pending;

  // Stimulus-owned knobs read by the idle generators.
  bit tx_idle_en    = 1'b0;
  bit rx_idle_en    = 1'b0;
  bit long_hold_go  = 1'b0;
  bit long_hold_done = 1'b0;   // owned by the receiver

  int items_sent = 0;
  int cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  area_average_line_downsampler DUT (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  aald_average_checker average_check (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .errors    (errors),
    .pending   (pending)
  );

  // Gap length: mostly none, often a few cycles, now and then a long one.
  function automatic int idle_gap(input bit on);
    int r;
    if (!on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Mix of rails, values near zero and full random words.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return SAMPLE_W'($signed($urandom_range(0, 16)) - 8);
      default: return w[SAMPLE_W-1:0];
    endcase
  endfunction

  // Samples needed to close the line (capped), give or take a few so that
  // some lines end short and some run into the full-line drop.
  function automatic int line_length(input logic [31:0] ratio_w, input logic [31:0] count_w);
    longint rr;
    longint n;
    int     len;
    rr = longint'(ratio_w[RATIO_W-1:0]);
    if (rr < 65537) begin
      rr = 65537;
    end
    n = longint'(count_w[DCOUNT_W-1:0]);
    if (n > 30) begin
      n = 30;
    end
    len = int'((n * rr + 65535) >>> 16) + $urandom_range(0, 4) - 1;
    return (len < 1) ? 1 : len;
  endfunction

  // Receiver: random ready pattern, or always ready, plus one long hold-off.
  initial begin
    int hold;
    forever begin
      if (long_hold_go && !long_hold_done) begin
        out_ready <= 1'b0;
        long_hold_done = 1'b1;
        hold = LONG_HOLD;
      end else if (!rx_idle_en) begin
        out_ready <= 1'b1;
        hold = 1;
      end else begin
        out_ready <= ($urandom_range(0, 99) < 70);
        hold = idle_gap(1'b1) + 1;
      end
      repeat (hold) @(posedge clk);
    end
  end

  // Hard stop in case a handshake never completes.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("area_average_line_downsampler verification failed");
    $finish;
  end

  task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [DATA_W-1:0] ratio_w, input logic [DATA_W-1:0] inv_w,
                            input logic [DATA_W-1:0] count_w);
    apb_write(REG_RATIO, ratio_w);
    apb_write(REG_INV, inv_w);
    apb_write(REG_COUNT, count_w);
  endtask

  // Offer one item and hold it until accepted; then maybe drop valid for a gap.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic first);
    int gap;
    in_valid <= 1'b1;
    in_item  <= '{sample: s, first_of_line: first};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    gap = idle_gap(tx_idle_en);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every expected output has come out and the block has gone quiet.
  task automatic drain_block();
    in_valid <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One line: first_of_line on the opening item, or scattered at random when
  // noisy. Some lines hold a single level to exercise saturation cleanly.
  task automatic send_line(input int len, input bit noisy);
    logic signed [SAMPLE_W-1:0] level;
    bit flat;
    logic first;
    flat  = ($urandom_range(0, 4) == 0);
    level = pick_sample();
    for (int i = 0; i < len; i++) begin
      first = noisy ? logic'($urandom_range(0, 1)) : (i == 0);
      push_sample(flat ? level : pick_sample(), first);
    end
  endtask

  task automatic random_phase(input int target, input bit idle_on, input bit with_hold);
    logic [DATA_W-1:0] ratio_w;
    logic [DATA_W-1:0] inv_w;
    logic [DATA_W-1:0] count_w;
    longint rr;
    int     base;
    case ($urandom_range(0, 9))
      0: ratio_w = 32'd0;
      1: ratio_w = 32'd65536;
      2: ratio_w = 32'd65537;
      3: ratio_w = 32'd131071;
      4: ratio_w = 32'd98304;
      5: ratio_w = $urandom_range(65537, 131071) | ($urandom & 32'hFFFE_0000);
      default: ratio_w = $urandom_range(65537, 131071);
    endcase
    rr = longint'(ratio_w[RATIO_W-1:0]);
    if (rr < 65537) begin
      rr = 65537;
    end
    case ($urandom_range(0, 9))
      0: inv_w = 32'd0;
      1: inv_w = 32'd65535;
      2: inv_w = 32'd32769;
      3: inv_w = $urandom;
      // Near the true reciprocal, nudged either way.
      default: inv_w = 32'((longint'(1) << 32) / rr) + $urandom_range(0, 6) - 3;
    endcase
    if (inv_w > 32'd65535 && inv_w < 32'd70000) begin
      inv_w = 32'd65535;
    end
    case ($urandom_range(0, 9))
      0: count_w = 32'd0;
      1: count_w = 32'd1;
      2: count_w = $urandom_range(4097, 8191) | ($urandom & 32'hFFFF_E000);
      3: count_w = $urandom_range(13, 40);
      default: count_w = $urandom_range(2, 12);
    endcase
    set_config(ratio_w, inv_w, count_w);
    tx_idle_en <= idle_on;
    rx_idle_en <= idle_on;
    if (with_hold) begin
      long_hold_go <= 1'b1;
    end
    base = items_sent;
    while (items_sent - base < target) begin
      send_line(line_length(ratio_w, count_w), ($urandom_range(0, 9) == 0));
    end
    drain_block();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, no first_of_line: reset state must already be a line start.
    // Ratio 1.5 also lands a boundary exactly on a sample end.
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh0000, 1'b0);
    push_sample(16'shFFFF, 1'b0);
    drain_block();

    // Ratio below range clamps to just above 1; short line, then drop samples.
    set_config(32'd0, 32'd65535, 32'd3);
    push_sample(16'sh7FFF, 1'b1);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh1234, 1'b0);
    push_sample(16'sh8000, 1'b1);
    drain_block();

    // Widest ratio with garbage in the upper bits, zero reciprocal.
    set_config(32'hFFFF_FFFF, 32'hFFFF_0000, 32'd2);
    push_sample(16'sh7FFF, 1'b1);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh5555, 1'b0);
    drain_block();

    // Zero outputs per line: everything is dropped.
    set_config(32'd98304, 32'd43691, 32'd0);
    push_sample(16'sh7FFF, 1'b1);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh0001, 1'b1);
    drain_block();

    // Count above the line maximum saturates: a short line under it must never
    // raise last_of_line. Run it flat out to keep it short.
    set_config(32'd65537, 32'd65535, 32'd8191);
    send_line(40, 1'b0);
    drain_block();

    // Random part: mostly well-formed lines, some noise; one phase without
    // any idling and one with the long receiver hold-off.
    for (int p = 0; p < 12; p++) begin
      random_phase(110, (p != 0), (p == 3));
    end

    drain_block();
    if (errors == 0 && pending == 0) begin
      $display("area_average_line_downsampler verification clean");
    end else begin
      $display("area_average_line_downsampler verification failed");
    end
    $finish;
  end

endmodule

[files.f]
design/aald_pkg.sv
design/aald_front.sv
design/aald_queue.sv
design/aald_back.sv
design/area_average_line_downsampler.sv
verif/aald_average_checker.sv
verif/area_average_line_downsampler_test.sv
